[rtl/vad_pkg.sv]
// Shared types and constants for the vector angle difference unit.
package vad_pkg;

    localparam int ZW = 26;
    localparam int DW = 28;
    localparam int OW = 17;
    localparam int TABLE_LEN = 24;

    localparam logic [1:0] FUNC_BETWEEN = 2'd0;
    localparam logic [1:0] FUNC_UNSIGNED_DIR = 2'd1;

    localparam logic signed [ZW-1:0] DEG90_Z = ZW'(90 * 65536);
    localparam logic signed [DW-1:0] DEG180 = DW'(180 * 65536);
    localparam logic signed [DW-1:0] DEG360 = DW'(360 * 65536);
    localparam logic signed [DW-1:0] ROUND_HALF = DW'(128);
    localparam logic signed [DW-8-1:0] OUT_LIMIT = (DW-8)'(46080);

    // atan(2^-i) in degrees, 16 fractional bits
    localparam logic [21:0] ATAN_Q16 [TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379, 22'd117304, 22'd58666, 22'd29335,
        22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115,
        22'd57, 22'd29, 22'd14, 22'd7,
        22'd4, 22'd2, 22'd1, 22'd0
    };

    typedef struct packed {
        logic       valid;
        logic [1:0] func;
        logic       zero_a;
        logic       zero_b;
    } t_ctl;

endpackage

[rtl/vector_angle_difference_unit.sv]
// Top level: angle between or direction of two vectors via pipelined CORDIC.
//
// Usage:
//   Command channel: drive i_func and the four coordinates with i_start high.
//   An item is taken at every clock edge where i_start is high and o_busy is
//   low; o_busy is always low, so one item can be taken in every cycle.
//   Result channel: o_valid is high for exactly one cycle with o_angle_deg
//   (signed Q8.8 degrees); it must be captured in that cycle.
//   The result passes one input stage, one cell per micro-rotation and
//   four combine stages. Throughput: one item per cycle, set by the fully
//   unrolled chain of CORDIC cells, one cell per micro-rotation.
//   Results come out in the order items went in.
//   Reset (i_rst_n low, synchronous) drops all items in flight; o_valid stays
//   low until new items have passed the pipeline.
//   The receiver cannot stall the result channel.
module vector_angle_difference_unit #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_func,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    output logic                          o_valid,
    output logic signed [vad_pkg::OW-1:0] o_angle_deg
);
    import vad_pkg::*;

    localparam int XW = COORD_WIDTH + 11;
    localparam int NS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    t_ctl                 w_ctl [NS+1];
    logic signed [XW-1:0] w_x [NS+1][2];
    logic signed [XW-1:0] w_y [NS+1][2];
    logic signed [ZW-1:0] w_z [NS+1][2];

    assign o_busy = 1'b0;

    vad_prep #(
        .COORD_WIDTH(COORD_WIDTH),
        .XW(XW)
    ) u_prep (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_func(i_func),
        .i_first_x(i_first_x),
        .i_first_y(i_first_y),
        .i_second_x(i_second_x),
        .i_second_y(i_second_y),
        .o_ctl(w_ctl[0]),
        .o_x(w_x[0]),
        .o_y(w_y[0]),
        .o_z(w_z[0])
    );

    for (genvar s = 0; s < NS; s++) begin : g_cell
        vad_cell #(
            .STAGE(s),
            .XW(XW)
        ) u_cell (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl(w_ctl[s]),
            .i_x(w_x[s]),
            .i_y(w_y[s]),
            .i_z(w_z[s]),
            .o_ctl(w_ctl[s+1]),
            .o_x(w_x[s+1]),
            .o_y(w_y[s+1]),
            .o_z(w_z[s+1])
        );
    end

    vad_combine u_combine (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl(w_ctl[NS]),
        .i_z(w_z[NS]),
        .o_valid(o_valid),
        .o_angle_deg(o_angle_deg)
    );

endmodule

[rtl/vad_prep.sv]
// Input stage: y flip for image modes, guard scaling, quadrant pre-rotation.
module vad_prep #(
    parameter int COORD_WIDTH = 24,
    parameter int XW = 35
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_func,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    output vad_pkg::t_ctl                 o_ctl,
    output logic signed [XW-1:0]          o_x [2],
    output logic signed [XW-1:0]          o_y [2],
    output logic signed [vad_pkg::ZW-1:0] o_z [2]
);
    import vad_pkg::*;

    logic signed [COORD_WIDTH-1:0] in_x [2];
    logic signed [COORD_WIDTH-1:0] in_y [2];
    logic signed [XW-1:0] n_x [2];
    logic signed [XW-1:0] n_y [2];
    logic signed [ZW-1:0] n_z [2];
    logic                 n_zero [2];
    logic signed [XW-1:0] r_x [2];
    logic signed [XW-1:0] r_y [2];
    logic signed [ZW-1:0] r_z [2];
    t_ctl                 r_ctl;

    assign in_x[0] = i_first_x;
    assign in_y[0] = i_first_y;
    assign in_x[1] = i_second_x;
    assign in_y[1] = i_second_y;

    for (genvar v = 0; v < 2; v++) begin : g_vec
        logic signed [XW-1:0] sx;
        logic signed [XW-1:0] sy;
        always_comb begin
            sx = XW'(in_x[v]) <<< 8;
            sy = XW'(in_y[v]) <<< 8;
            if (i_func != FUNC_BETWEEN) begin
                sy = -sy;
            end
            n_zero[v] = (in_x[v] == '0) && (in_y[v] == '0);
            n_x[v] = sx;
            n_y[v] = sy;
            n_z[v] = '0;
            if (sx < 0) begin
                if (sy >= 0) begin
                    n_x[v] = sy;
                    n_y[v] = -sx;
                    n_z[v] = DEG90_Z;
                end else begin
                    n_x[v] = -sy;
                    n_y[v] = sx;
                    n_z[v] = -DEG90_Z;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl.func   <= i_func;
        r_ctl.zero_a <= n_zero[0];
        r_ctl.zero_b <= n_zero[1];
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

[rtl/vad_cell.sv]
// One CORDIC vectoring micro-rotation for both vectors, registered.
module vad_cell #(
    parameter int STAGE = 0,
    parameter int XW = 35
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vad_pkg::t_ctl                 i_ctl,
    input  logic signed [XW-1:0]          i_x [2],
    input  logic signed [XW-1:0]          i_y [2],
    input  logic signed [vad_pkg::ZW-1:0] i_z [2],
    output vad_pkg::t_ctl                 o_ctl,
    output logic signed [XW-1:0]          o_x [2],
    output logic signed [XW-1:0]          o_y [2],
    output logic signed [vad_pkg::ZW-1:0] o_z [2]
);
    import vad_pkg::*;

    localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_Q16[STAGE]);

    logic signed [XW-1:0] n_x [2];
    logic signed [XW-1:0] n_y [2];
    logic signed [ZW-1:0] n_z [2];
    logic signed [XW-1:0] r_x [2];
    logic signed [XW-1:0] r_y [2];
    logic signed [ZW-1:0] r_z [2];
    t_ctl                 r_ctl;

    for (genvar v = 0; v < 2; v++) begin : g_vec
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        assign xs = i_x[v] >>> STAGE;
        assign ys = i_y[v] >>> STAGE;
        always_comb begin
            if (i_y[v] < 0) begin
                n_x[v] = i_x[v] - ys;
                n_y[v] = i_y[v] + xs;
                n_z[v] = i_z[v] - ANG;
            end else begin
                n_x[v] = i_x[v] + ys;
                n_y[v] = i_y[v] - xs;
                n_z[v] = i_z[v] + ANG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl.func   <= i_ctl.func;
        r_ctl.zero_a <= i_ctl.zero_a;
        r_ctl.zero_b <= i_ctl.zero_b;
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

[rtl/vad_combine.sv]
// Angle combination, folding, rounding to Q8.8 and clamping over four stages.
module vad_combine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vad_pkg::t_ctl                 i_ctl,
    input  logic signed [vad_pkg::ZW-1:0] i_z [2],
    output logic                          o_valid,
    output logic signed [vad_pkg::OW-1:0] o_angle_deg
);
    import vad_pkg::*;

    logic signed [DW-1:0] e1, e2, p, q;
    logic signed [DW-1:0] n_da, n_db, n_dc;
    logic signed [DW-8-1:0] rnd;
    logic signed [OW-1:0] n_out;
    logic signed [DW-1:0] r_da, r_db, r_dc;
    logic [1:0]           r_fa, r_fb;
    logic [3:0]           r_vld;
    logic signed [OW-1:0] r_out;

    // stage A: difference, magnitude for the unsigned between mode
    always_comb begin
        e1 = i_ctl.zero_a ? '0 : DW'(i_z[0]);
        e2 = i_ctl.zero_b ? '0 : DW'(i_z[1]);
        p  = e1 - e2;
        q  = e2 - e1;
        if (i_ctl.func == FUNC_BETWEEN) begin
            n_da = p[DW-1] ? q : p;
        end else begin
            n_da = q;
        end
    end

    // stage B: fold to 0..180 or reduce modulo 360
    always_comb begin
        if (r_fa == FUNC_BETWEEN) begin
            n_db = (r_da >= DEG180) ? DEG360 - r_da : r_da;
        end else if (r_da < 0) begin
            n_db = r_da + DEG360;
        end else if (r_da >= DEG360) begin
            n_db = r_da - DEG360;
        end else begin
            n_db = r_da;
        end
    end

    // stage C: direction folding
    always_comb begin
        n_dc = r_db;
        if (r_fb != FUNC_BETWEEN && r_db > DEG180) begin
            n_dc = r_db - ((r_fb == FUNC_UNSIGNED_DIR) ? DEG180 : DEG360);
        end
    end

    // stage D: round and clamp
    always_comb begin
        rnd = (DW-8)'((r_dc + ROUND_HALF) >>> 8);
        if (rnd > OUT_LIMIT) begin
            n_out = OW'(OUT_LIMIT);
        end else if (rnd < -OUT_LIMIT) begin
            n_out = OW'(-OUT_LIMIT);
        end else begin
            n_out = OW'(rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_da  <= n_da;
        r_fa  <= i_ctl.func;
        r_db  <= n_db;
        r_fb  <= r_fa;
        r_dc  <= n_dc;
        r_out <= n_out;
    end

    assign o_valid     = r_vld[3];
    assign o_angle_deg = r_out;

endmodule
